// ===== sv/pbqp_pkg.sv =====
// Shared types and constants for the PBQP cost matrix engine.
// Used by the front end, the back end and the top level.
`default_nettype none
package pbqp_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 32;
	localparam int COST_BITS = 32;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int CNT_W     = 6;
	localparam int REQ_W     = 4;
	localparam int IDX_W     = 5;
	localparam int VAL_W     = 32;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 40;

	localparam logic [COST_BITS-1:0] INF_COST = '1;
	localparam logic [CNT_W-1:0] ROWS_MAX = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] COLS_MAX = CNT_W'(MAX_COLS);

	// Request codes on the input stream.
	localparam logic [REQ_W-1:0] REQ_WRITE   = 4'd0;
	localparam logic [REQ_W-1:0] REQ_ACC     = 4'd1;
	localparam logic [REQ_W-1:0] REQ_LDROW   = 4'd2;
	localparam logic [REQ_W-1:0] REQ_LDCOL   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_ADDROWS = 4'd4;
	localparam logic [REQ_W-1:0] REQ_ADDCOLS = 4'd5;
	localparam logic [REQ_W-1:0] REQ_ROWMIN  = 4'd6;
	localparam logic [REQ_W-1:0] REQ_COLMIN  = 4'd7;
	localparam logic [REQ_W-1:0] REQ_SUBROW  = 4'd8;
	localparam logic [REQ_W-1:0] REQ_SUBCOL  = 4'd9;
	localparam logic [REQ_W-1:0] REQ_ISZERO  = 4'd10;

	// Configuration register indexes.
	localparam logic [0:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [0:0] CFG_NUM_COLS = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP, OP_WRITE, OP_ACC, OP_LDROW, OP_LDCOL, OP_ADDROWS, OP_ADDCOLS,
		OP_ROWMIN, OP_COLMIN, OP_SUBROW, OP_SUBCOL, OP_ISZERO
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		logic [COST_BITS-1:0] value;
		logic [CNT_W-1:0]     nr;
		logic [CNT_W-1:0]     nc;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_START, ST_READ, ST_EXEC
	} state_t;

endpackage
`default_nettype wire

// ===== sv/pbqp_front.sv =====
// Front end: configuration registers, request classification and a
// two-entry command queue. Depends on pbqp_pkg.
`default_nettype none
module pbqp_front import pbqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data,
	output logic                  cmd_valid,
	output cmd_t                  cmd,
	input  wire logic             cmd_pop
);

	logic [CNT_W-1:0] num_rows_q, num_cols_q;
	logic [CNT_W-1:0] nr, nc;
	logic [REQ_W-1:0] req;
	logic [IDX_W-1:0] r, c;
	logic             r_ok, c_ok;
	op_t              op;
	cmd_t             queue_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;

	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CNT_W'(1);
			num_cols_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_NUM_ROWS) num_rows_q <= cfg_data;
			else num_cols_q <= cfg_data;
		end
	end

	// Decode and check indices against the active sizes.
	assign nr   = (num_rows_q > ROWS_MAX) ? ROWS_MAX : num_rows_q;
	assign nc   = (num_cols_q > COLS_MAX) ? COLS_MAX : num_cols_q;
	assign req  = s_tdata[3:0];
	assign r    = s_tdata[8:4];
	assign c    = s_tdata[13:9];
	assign r_ok = {1'b0, r} < nr;
	assign c_ok = {1'b0, c} < nc;

	always_comb begin
		op = OP_NOP;
		unique case (req)
			REQ_WRITE:   if (r_ok && c_ok) op = OP_WRITE;
			REQ_ACC:     if (r_ok && c_ok) op = OP_ACC;
			REQ_LDROW:   if (r_ok) op = OP_LDROW;
			REQ_LDCOL:   if (c_ok) op = OP_LDCOL;
			REQ_ADDROWS: op = OP_ADDROWS;
			REQ_ADDCOLS: op = OP_ADDCOLS;
			REQ_ROWMIN:  if (r_ok) op = OP_ROWMIN;
			REQ_COLMIN:  if (c_ok) op = OP_COLMIN;
			REQ_SUBROW:  if (r_ok) op = OP_SUBROW;
			REQ_SUBCOL:  if (c_ok) op = OP_SUBCOL;
			REQ_ISZERO:  op = OP_ISZERO;
			default:     op = OP_NOP;
		endcase
	end

	// Command queue between the front and the back end.
	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{op: op, row: r[ROW_W-1:0], col: c[COL_W-1:0],
				value: s_tdata[45:14], nr: nr, nc: nc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

// ===== sv/pbqp_back.sv =====
// Back end: walks the cost matrix memory for one command at a time and
// holds the result in an output register. Depends on pbqp_pkg.
`default_nettype none
module pbqp_back import pbqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire cmd_t             cmd,
	output logic                  cmd_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	logic [COST_BITS-1:0] mem [2**ADDR_W];
	logic [COST_BITS-1:0] row_vec_q [MAX_ROWS];
	logic [COST_BITS-1:0] col_vec_q [MAX_COLS];
	logic [COST_BITS-1:0] rdata_q;

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [ROW_W-1:0]     i_q;
	logic [COL_W-1:0]     j_q, j0_q;
	logic [CNT_W-1:0]     lim_i_q, lim_j_q;
	logic [COST_BITS-1:0] min_q;
	logic                 zflag_q;
	logic                 out_valid_q;
	logic [COST_BITS-1:0] out_res_q;
	logic                 out_zero_q;

	logic                 last_i, last_j, empty_walk, walk_done;
	logic [COST_BITS-1:0] rv, cv, operand, new_e, min_d;
	logic [COST_BITS:0]   sum;
	logic                 zflag_d, mem_we, finish;
	logic [COST_BITS-1:0] fin_res;
	logic                 fin_zero;

	assign rv         = row_vec_q[i_q];
	assign cv         = col_vec_q[j_q];
	assign last_i     = ({1'b0, i_q} + CNT_W'(1)) == lim_i_q;
	assign last_j     = ({1'b0, j_q} + CNT_W'(1)) == lim_j_q;
	assign walk_done  = last_i && last_j;
	assign empty_walk = (lim_i_q <= {1'b0, i_q}) || (lim_j_q <= {1'b0, j0_q});
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd_pop) state_d = ST_START;
			ST_START: begin
				priority if (cmd_q.op == OP_NOP || cmd_q.op == OP_WRITE ||
						cmd_q.op == OP_LDROW || cmd_q.op == OP_LDCOL || empty_walk)
					state_d = ST_IDLE;
				else
					state_d = ST_READ;
			end
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = walk_done ? ST_IDLE : ST_READ;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Per-entry arithmetic for the entry just read.
	always_comb begin
		unique case (cmd_q.op)
			OP_ADDROWS: operand = cv;
			OP_ADDCOLS: operand = rv;
			default:    operand = cmd_q.value;
		endcase
		sum = {1'b0, rdata_q} + {1'b0, operand};
		unique case (cmd_q.op)
			OP_SUBROW, OP_SUBCOL:
				new_e = (rdata_q == INF_COST && operand != INF_COST) ?
					rdata_q : rdata_q - operand;
			default:
				new_e = (sum >= {1'b0, INF_COST}) ? INF_COST : sum[COST_BITS-1:0];
		endcase
		min_d = min_q;
		if (cmd_q.op == OP_ROWMIN && cv != INF_COST && rdata_q < min_q) min_d = rdata_q;
		if (cmd_q.op == OP_COLMIN && rv != INF_COST && rdata_q < min_q) min_d = rdata_q;
		zflag_d = zflag_q;
		if (rv != INF_COST && cv != INF_COST && rdata_q != '0) zflag_d = 1'b0;
	end

	// Write enable, completion and result selection.
	always_comb begin
		mem_we   = (state_q == ST_START && cmd_q.op == OP_WRITE) ||
			(state_q == ST_EXEC && (cmd_q.op == OP_ACC || cmd_q.op == OP_ADDROWS ||
			cmd_q.op == OP_ADDCOLS || cmd_q.op == OP_SUBROW || cmd_q.op == OP_SUBCOL));
		finish   = (state_q != ST_IDLE) && (state_d == ST_IDLE);
		fin_res  = '0;
		fin_zero = 1'b0;
		unique case (cmd_q.op)
			OP_WRITE:  fin_res = cmd_q.value;
			OP_ACC:    fin_res = new_e;
			OP_ROWMIN, OP_COLMIN: fin_res = (state_q == ST_EXEC) ? min_d : INF_COST;
			OP_ISZERO: fin_zero = (state_q == ST_EXEC) ? zflag_d : 1'b1;
			default:   fin_res = '0;
		endcase
	end

	// Matrix memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[{i_q, j_q}] <= (cmd_q.op == OP_WRITE) ? cmd_q.value : new_e;
		if (state_q == ST_READ) rdata_q <= mem[{i_q, j_q}];
	end

	// Vector loads.
	always_ff @(posedge clk) begin
		if (state_q == ST_START && cmd_q.op == OP_LDROW) row_vec_q[cmd_q.row] <= cmd_q.value;
		if (state_q == ST_START && cmd_q.op == OP_LDCOL) col_vec_q[cmd_q.col] <= cmd_q.value;
	end

	// Command capture and walk counters.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q   <= cmd;
			min_q   <= INF_COST;
			zflag_q <= 1'b1;
			i_q     <= '0;
			lim_i_q <= cmd.nr;
			j_q     <= '0;
			j0_q    <= '0;
			lim_j_q <= cmd.nc;
			if (cmd.op == OP_WRITE || cmd.op == OP_ACC || cmd.op == OP_ROWMIN ||
					cmd.op == OP_SUBROW) begin
				i_q     <= cmd.row;
				lim_i_q <= {1'b0, cmd.row} + CNT_W'(1);
			end
			if (cmd.op == OP_WRITE || cmd.op == OP_ACC || cmd.op == OP_COLMIN ||
					cmd.op == OP_SUBCOL) begin
				j_q     <= cmd.col;
				j0_q    <= cmd.col;
				lim_j_q <= {1'b0, cmd.col} + CNT_W'(1);
			end
		end else if (state_q == ST_EXEC) begin
			min_q   <= min_d;
			zflag_q <= zflag_d;
			if (last_j) begin
				j_q <= j0_q;
				i_q <= i_q + ROW_W'(1);
			end else begin
				j_q <= j_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Output register; a result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (finish) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_res_q  <= fin_res;
			out_zero_q <= fin_zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_zero_q, out_res_q};

endmodule
`default_nettype wire

// ===== sv/pbqp_cost_matrix_engine.sv =====
// Top level of the PBQP cost matrix engine.
// Connects pbqp_front and pbqp_back; depends on pbqp_pkg.
//
// Requests enter a two-entry queue and are carried out one at a time by a
// sequencer on a single-port 1024 x 32 matrix memory; each visited entry
// is read, then updated. Exactly one result comes back for each request.
// Configuration writes take effect for requests accepted afterwards.
`default_nettype none
module pbqp_cost_matrix_engine import pbqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// [3:0] req_type, [8:4] row_num, [13:9] col_num, [45:14] operand_value
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// [31:0] result_value, [32] all_zero
	output logic [OUT_W-1:0]      m_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data
);

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	pbqp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	pbqp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
`default_nettype wire

// ===== test/pbqp_checker.sv =====
// Scoreboard for the PBQP cost matrix engine: watches the request, result and
// configuration channels, predicts every result and compares it.
// Depends on pbqp_pkg for widths, request codes and register indexes.
`timescale 1ns / 1ps
module pbqp_checker import pbqp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic             cfg_valid,
	input  wire logic             cfg_ready,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct {
		logic [31:0] value;
		logic        zero;
	} answer_t;

	// Shadow copy of the engine state.
	logic [CNT_W-1:0] rows_reg = 6'd1;
	logic [CNT_W-1:0] cols_reg = 6'd1;
	logic [31:0]      matrix [MAX_ROWS*MAX_COLS];
	logic [31:0]      row_costs [MAX_ROWS];
	logic [31:0]      col_costs [MAX_COLS];
	answer_t          answers_due [$];

	initial begin
		fail_count = 0;
		pending = 0;
		for (int k = 0; k < MAX_ROWS*MAX_COLS; k++) matrix[k] = '0;
		for (int k = 0; k < MAX_ROWS; k++) row_costs[k] = '0;
		for (int k = 0; k < MAX_COLS; k++) col_costs[k] = '0;
	end

	// Addition that clamps at infinity.
	function automatic logic [31:0] clamp_add(logic [31:0] x, logic [31:0] y);
		logic [32:0] sum;
		sum = {1'b0, x} + {1'b0, y};
		return sum[32] ? INF_COST : sum[31:0];
	endfunction

	// Subtraction that keeps infinity unless infinity itself is removed.
	function automatic logic [31:0] inf_minus(logic [31:0] e, logic [31:0] v);
		if (e == INF_COST && v != INF_COST) return e;
		return e - v;
	endfunction

	// Apply one request to the shadow state and return its answer.
	task automatic apply_request(input logic [IN_W-1:0] d, output answer_t ans);
		logic [REQ_W-1:0] req;
		int r, c, nr, nc;
		logic [31:0] v;
		logic r_ok, c_ok;
		req = d[3:0];
		r = d[8:4];
		c = d[13:9];
		v = d[45:14];
		nr = (rows_reg > ROWS_MAX) ? MAX_ROWS : rows_reg;
		nc = (cols_reg > COLS_MAX) ? MAX_COLS : cols_reg;
		r_ok = r < nr;
		c_ok = c < nc;
		ans.value = '0;
		ans.zero = 1'b0;
		case (req)
			REQ_WRITE, REQ_ACC: begin
				if (r_ok && c_ok) begin
					if (req == REQ_WRITE) matrix[r*MAX_COLS+c] = v;
					else matrix[r*MAX_COLS+c] = clamp_add(matrix[r*MAX_COLS+c], v);
					ans.value = matrix[r*MAX_COLS+c];
				end
			end
			REQ_LDROW: if (r_ok) row_costs[r] = v;
			REQ_LDCOL: if (c_ok) col_costs[c] = v;
			REQ_ADDROWS, REQ_ADDCOLS: begin
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						matrix[i*MAX_COLS+j] = clamp_add(matrix[i*MAX_COLS+j],
							(req == REQ_ADDROWS) ? col_costs[j] : row_costs[i]);
			end
			REQ_ROWMIN: begin
				if (r_ok) begin
					ans.value = INF_COST;
					for (int j = 0; j < nc; j++)
						if (col_costs[j] != INF_COST && matrix[r*MAX_COLS+j] < ans.value)
							ans.value = matrix[r*MAX_COLS+j];
				end
			end
			REQ_COLMIN: begin
				if (c_ok) begin
					ans.value = INF_COST;
					for (int i = 0; i < nr; i++)
						if (row_costs[i] != INF_COST && matrix[i*MAX_COLS+c] < ans.value)
							ans.value = matrix[i*MAX_COLS+c];
				end
			end
			REQ_SUBROW: begin
				if (r_ok)
					for (int j = 0; j < nc; j++)
						matrix[r*MAX_COLS+j] = inf_minus(matrix[r*MAX_COLS+j], v);
			end
			REQ_SUBCOL: begin
				if (c_ok)
					for (int i = 0; i < nr; i++)
						matrix[i*MAX_COLS+c] = inf_minus(matrix[i*MAX_COLS+c], v);
			end
			REQ_ISZERO: begin
				ans.zero = 1'b1;
				for (int i = 0; i < nr; i++)
					for (int j = 0; j < nc; j++)
						if (row_costs[i] != INF_COST && col_costs[j] != INF_COST
								&& matrix[i*MAX_COLS+j] != 0)
							ans.zero = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Print one mismatch and count it.
	task automatic report(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Compare result transfers, then record new requests and register writes.
	always @(posedge clk) begin
		answer_t ans;
		if (m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report("unexpected result", m_tdata[31:0], '0);
			end else begin
				ans = answers_due.pop_front();
				if (m_tdata[31:0] !== ans.value)
					report("result_value", m_tdata[31:0], ans.value);
				if (m_tdata[32] !== ans.zero)
					report("all_zero", {31'b0, m_tdata[32]}, {31'b0, ans.zero});
			end
		end
		if (s_tvalid && s_tready) begin
			apply_request(s_tdata, ans);
			answers_due.push_back(ans);
		end
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_NUM_ROWS) rows_reg = cfg_data;
			else cols_reg = cfg_data;
		end
		pending = answers_due.size();
	end

endmodule

// ===== test/tb_pbqp_cost_matrix_engine.sv =====
// Testbench top for the PBQP cost matrix engine: drives requests, register
// writes and backpressure, and gives the verdict from pbqp_checker's count.
// Depends on pbqp_pkg, pbqp_checker and the engine RTL.
`timescale 1ns / 1ps
module tb_pbqp_cost_matrix_engine;
	import pbqp_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 4'd11;
	localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 4'd15;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [0:0]       cfg_index = CFG_NUM_ROWS;
	logic [CNT_W-1:0] cfg_data = '0;
	int               fail_count;
	int               pending;

	int tx_idle = 0;
	int rx_idle = 0;
	int hold_asks = 0;
	int hold_done = 0;
	int hold_left = 0;
	int sent = 0;
	int cur_rows = 1;
	int cur_cols = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	pbqp_cost_matrix_engine DUT (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	pbqp_checker scoreboard (
		.clk, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
	);

	// Receiver: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Offer one request, idling first at random, and wait for its transfer.
	task automatic send(input logic [REQ_W-1:0] req, input int r, input int c,
			input logic [31:0] v);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b0, v, 5'(c), 5'(r), req};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Register write, issued only once the engine has drained.
	task automatic set_size(input int rows, input int cols);
		s_tvalid <= 1'b0;
		// Let the checker record the last request before its count is read.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_NUM_ROWS;
		cfg_data <= CNT_W'(rows);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_NUM_COLS;
		cfg_data <= CNT_W'(cols);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
		cur_cols = (cols > MAX_COLS) ? MAX_COLS : cols;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return INF_COST;
			1: return '0;
			2, 3: return $urandom;
			4: return INF_COST - $urandom_range(3);
			default: return $urandom_range(1000);
		endcase
	endfunction

	function automatic int pick_index(input int n);
		if (n == 0 || $urandom_range(9) == 0) return $urandom_range(31);
		return $urandom_range(n - 1);
	endfunction

	// One random request; whole-matrix walks are kept rare.
	task automatic send_random();
		int w;
		logic [REQ_W-1:0] req;
		w = $urandom_range(99);
		if (w < 18) req = REQ_WRITE;
		else if (w < 32) req = REQ_ACC;
		else if (w < 40) req = REQ_LDROW;
		else if (w < 48) req = REQ_LDCOL;
		else if (w < 56) req = REQ_ROWMIN;
		else if (w < 64) req = REQ_COLMIN;
		else if (w < 74) req = REQ_SUBROW;
		else if (w < 84) req = REQ_SUBCOL;
		else if (w < 87) req = REQ_ADDROWS;
		else if (w < 90) req = REQ_ADDCOLS;
		else if (w < 95) req = REQ_ISZERO;
		else req = 4'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
		send(req, pick_index(cur_rows), pick_index(cur_cols), pick_value());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Fill every entry and vector element so no read ever sees an unwritten one.
		tx_idle = 13;
		rx_idle = 84;
		set_size(32, 32);
		for (int i = 0; i < MAX_ROWS; i++) send(REQ_LDROW, i, 0, $urandom_range(50));
		for (int j = 0; j < MAX_COLS; j++) send(REQ_LDCOL, 0, j, $urandom_range(50));
		for (int k = 0; k < MAX_ROWS*MAX_COLS; k++)
			send(REQ_WRITE, k / MAX_COLS, k % MAX_COLS, $urandom_range(5000));

		// Directed cases: saturation, deleted elements, infinity arithmetic.
		send(REQ_WRITE, 31, 31, INF_COST);
		send(REQ_ACC, 31, 31, 32'd5);
		send(REQ_WRITE, 0, 0, 32'hFFFF_FFF0);
		send(REQ_ACC, 0, 0, 32'h20);
		send(REQ_ACC, 0, 1, 32'd0);
		send(REQ_LDCOL, 0, 3, INF_COST);
		send(REQ_ROWMIN, 0, 0, 32'd0);
		send(REQ_LDROW, 2, 0, INF_COST);
		send(REQ_COLMIN, 0, 3, 32'd0);
		send(REQ_SUBROW, 31, 0, 32'd7);
		send(REQ_SUBCOL, 0, 31, INF_COST);
		send(REQ_SUBROW, 5, 0, 32'hFFFF_FFFE);
		send(REQ_ADDROWS, 0, 0, 32'd0);
		send(REQ_ADDCOLS, 0, 0, 32'd0);
		send(REQ_ISZERO, 0, 0, 32'd0);
		send(REQ_UNDEF_LO, 1, 1, 32'd9);
		send(REQ_UNDEF_HI, 1, 1, 32'd9);
		set_size(1, 1);
		send(REQ_WRITE, 0, 0, 32'd0);
		send(REQ_ISZERO, 0, 0, 32'd0);
		send(REQ_WRITE, 1, 0, 32'd3);
		send(REQ_ROWMIN, 0, 1, 32'd0);
		set_size(0, 0);
		send(REQ_ROWMIN, 0, 0, 32'd0);
		send(REQ_ADDROWS, 0, 0, 32'd0);
		send(REQ_ISZERO, 0, 0, 32'd0);
		set_size(63, 63);
		send(REQ_COLMIN, 0, 31, 32'd0);

		// Random phases with three idle profiles and changing sizes.
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = (phase == 0) ? 13 : (phase == 1) ? 84 : 0;
			rx_idle = (phase == 0) ? 84 : (phase == 1) ? 13 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				case ((phase * 4 + blk) % 6)
					0: set_size(32, 32);
					1: set_size(0, $urandom_range(63));
					2: set_size(40, 1);
					default: set_size($urandom_range(6, 1), $urandom_range(6, 1));
				endcase
				if (phase == 2 && blk == 1) hold_asks++;
				for (int n = 0; n < 36; n++) send_random();
			end
		end
		s_tvalid <= 1'b0;

		// Drain, then allow time for anything stray.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
		$display("Covered %0d requests at sizes 0 to 63, three idle profiles,", sent);
		$display("a long result hold-off, and every request code.");
		if (fail_count == 0)
			$display("[pbqp_cost_matrix_engine] OK");
		else
			$display("[pbqp_cost_matrix_engine] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[pbqp_cost_matrix_engine] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pbqp_pkg.sv
sv/pbqp_front.sv
sv/pbqp_back.sv
sv/pbqp_cost_matrix_engine.sv
test/pbqp_checker.sv
test/tb_pbqp_cost_matrix_engine.sv
